/* design/chacha20_stream_cipher_assert.svh */
// Assertion macros used by the chacha20_stream_cipher RTL.
// Expects clk and rst_n in the including module; no other dependencies.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define CC20_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: assertion failed");
`define CC20_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: assertion failed");
`else
`define CC20_ASSERT_IMP(label, a, b)
`define CC20_ASSERT_NEXT(label, a, b)
`endif

`endif

/* design/cc20_pkg.sv */
// Shared types, constants and block-function helpers for chacha20_stream_cipher.
// No dependencies.
`default_nettype none

package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int QUEUE_DEPTH       = 4;
    localparam int CHUNKS            = 8;
    localparam int CFG_IDX_W         = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam int QR_IDX [8][4] = '{
        '{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
        '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13}, '{3, 4, 9, 14}
    };

    typedef logic [31:0] word_t;
    typedef logic [15:0][31:0] state_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        need;
        logic [31:0] ctr;
        logic [2:0]  offset;
    } chunk_t;

    typedef struct packed {
        logic [255:0] key;
        logic [95:0]  nonce;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic word_t rotl(input word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [3:0][31:0] quarter(input word_t a, input word_t b,
                                                 input word_t c, input word_t d);
        word_t ta;
        word_t tb;
        word_t tc;
        word_t td;
        ta = a;
        tb = b;
        tc = c;
        td = d;
        ta = ta + tb; td = rotl(td ^ ta, 16);
        tc = tc + td; tb = rotl(tb ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        return {td, tc, tb, ta};
    endfunction

    function automatic state_t double_round(input state_t w);
        state_t s;
        logic [3:0][31:0] q;
        s = w;
        for (int i = 0; i < 8; i++)
        begin
            q = quarter(s[QR_IDX[i][0]], s[QR_IDX[i][1]], s[QR_IDX[i][2]], s[QR_IDX[i][3]]);
            s[QR_IDX[i][0]] = q[0];
            s[QR_IDX[i][1]] = q[1];
            s[QR_IDX[i][2]] = q[2];
            s[QR_IDX[i][3]] = q[3];
        end
        return s;
    endfunction

    function automatic state_t init_state(input cfg_t cfg, input logic [31:0] ctr);
        state_t s;
        s[0] = SIGMA0;
        s[1] = SIGMA1;
        s[2] = SIGMA2;
        s[3] = SIGMA3;
        for (int j = 0; j < 8; j++)
        begin
            s[4 + j] = cfg.key[32 * j +: 32];
        end
        s[12] = ctr;
        s[13] = cfg.nonce[31:0];
        s[14] = cfg.nonce[63:32];
        s[15] = cfg.nonce[95:64];
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/cc20_front.sv */
// Front end: accepts chunks, tracks block counter and chunk offset, tags block requests.
// Depends on cc20_pkg.
`default_nettype none

module cc20_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [63:0]        data_in,
    input  wire logic [3:0]         byte_count,
    input  wire logic               first_of_message,
    input  wire logic               restart_counter,
    input  wire logic [31:0]        init_ctr,
    input  wire logic               q_full,
    output logic                    push,
    output cc20_pkg::chunk_t        entry
);

    logic [31:0] ctr_reg, ctr_next;
    logic [2:0]  ofs_reg, ofs_next;
    logic        ready_reg, ready_next;
    logic [31:0] ctr_eff;
    logic        need;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign ctr_eff  = restart_counter ? init_ctr : ctr_reg;
    assign need     = first_of_message || !ready_reg;

    always_comb
    begin
        entry.data   = data_in;
        entry.count  = byte_count;
        entry.need   = need;
        entry.ctr    = ctr_eff;
        entry.offset = need ? 3'd0 : ofs_reg;
        ctr_next     = need ? ctr_eff + 32'd1 : ctr_eff;
        ofs_next     = entry.offset + 3'd1;
        ready_next   = (entry.offset != 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg   <= '0;
            ofs_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else if (push)
        begin
            ctr_reg   <= ctr_next;
            ofs_reg   <= ofs_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

/* design/cc20_fifo.sv */
// Short queue of classified chunks between front and back end.
// Depends on cc20_pkg.
`default_nettype none

module cc20_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cc20_pkg::chunk_t   wr_entry,
    output logic                    full,
    output logic                    q_valid,
    input  wire logic               pop,
    output cc20_pkg::chunk_t        head
);

    localparam int DEPTH = cc20_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cc20_pkg::chunk_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/cc20_core.sv */
// Iterative ChaCha20 block function, one double round per cycle.
// Depends on cc20_pkg.
`default_nettype none

module cc20_core #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire cc20_pkg::state_t   init,
    output cc20_pkg::core_stat_t    stat,
    output cc20_pkg::state_t        ks
);

    localparam int RW = $clog2(DOUBLE_ROUNDS + 1);

    cc20_pkg::state_t w_reg, w_next;
    logic [RW-1:0]    rnd_reg;
    logic             busy_reg;
    logic             done;

    assign done      = busy_reg && (rnd_reg == RW'(DOUBLE_ROUNDS));
    assign stat.busy = busy_reg;
    assign stat.done = done;
    assign w_next    = cc20_pkg::double_round(busy_reg ? w_reg : init);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            ks[i] = w_reg[i] + init[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((start && !busy_reg) || (busy_reg && !done))
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else if (!busy_reg)
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= RW'(1);
            end
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            rnd_reg <= rnd_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

/* design/cc20_back.sv */
// Back end: runs the block core on request, holds the keystream, XORs and masks chunks.
// Depends on cc20_pkg, cc20_core and chacha20_stream_cipher_assert.svh.
`default_nettype none
`include "chacha20_stream_cipher_assert.svh"

module cc20_back #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cc20_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    input  wire cc20_pkg::chunk_t   head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [63:0]             data_out,
    output logic [3:0]              valid_bytes
);

    cc20_pkg::core_stat_t stat;
    cc20_pkg::state_t     init;
    cc20_pkg::state_t     ks;
    logic [63:0]          store_reg [cc20_pkg::CHUNKS];
    logic                 fresh_reg;
    logic                 core_start;
    logic                 slot_free;
    logic                 emit;
    logic [63:0]          mask;
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;
    logic [3:0]           out_cnt_reg;

    assign init       = cc20_pkg::init_state(cfg, head.ctr);
    assign core_start = q_valid && head.need && !fresh_reg && !stat.busy;
    assign slot_free  = !out_valid_reg || m_tready;
    assign emit       = q_valid && (!head.need || fresh_reg) && slot_free;
    assign pop        = emit;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mask[8 * i +: 8] = (head.count > 4'(i)) ? 8'hFF : 8'h00;
        end
    end

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .init  (init),
        .stat  (stat),
        .ks    (ks)
    );

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            for (int i = 0; i < cc20_pkg::CHUNKS; i++)
            begin
                store_reg[i] <= {ks[2 * i + 1], ks[2 * i]};
            end
        end
        if (emit)
        begin
            out_data_reg <= (head.data ^ store_reg[head.offset]) & mask;
            out_cnt_reg  <= head.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (stat.done)
            begin
                fresh_reg <= 1'b1;
            end
            else if (emit && head.need)
            begin
                fresh_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign data_out    = out_data_reg;
    assign valid_bytes = out_cnt_reg;

    `CC20_ASSERT_IMP(a_busy_not_fresh, stat.busy, !fresh_reg)
    `CC20_ASSERT_NEXT(a_start_busy, core_start, stat.busy)
    `CC20_ASSERT_NEXT(a_done_fresh, stat.done, fresh_reg && !stat.busy)

endmodule

`default_nettype wire

/* design/chacha20_stream_cipher.sv */
// ChaCha20 stream cipher (RFC 8439 block function), 8-byte chunk XOR stage.
// Depends on cc20_pkg, cc20_front, cc20_fifo and cc20_back.
//
// Usage:
//   s_*   : input chunk beats. s_tdata = data_in[63:0], byte_count[67:64];
//           s_tuser = first_of_message[0], restart_counter[1].
//   m_*   : result beats. m_tdata = data_out[63:0], valid_bytes[67:64].
//   cfg_* : register writes (key 0..3, nonce lo/hi, initial counter), always
//           ready; write only while no beat is in flight.
// A beat that needs a fresh keystream block waits at the queue head while the
//   one-double-round-per-cycle core computes that block, then passes the result
//   register; other beats go from the queue head straight to the result register.
//   A block is computed only once a beat that needs it is at the queue head.
// The front keeps accepting into a 4-entry queue while the core works.
// Reset clears the counter, offset, queue and config registers; no block held.
// When m_tready is low the result register holds and the queue fills, then
// s_tready drops.
`default_nettype none

module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [71:0]                       s_tdata,  // data_in, byte_count
    input  wire logic [1:0]                        s_tuser,  // first_of_message, restart
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [71:0]                            m_tdata,  // data_out, valid_bytes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [63:0]                       cfg_data
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] init_ctr_reg;

    cc20_pkg::cfg_t   cfg;
    cc20_pkg::chunk_t wr_entry;
    cc20_pkg::chunk_t head;
    logic             push;
    logic             full;
    logic             q_valid;
    logic             pop;
    logic [63:0]      data_out;
    logic [3:0]       valid_bytes;

    assign cfg_ready = 1'b1;
    assign cfg.key   = {key3_reg, key2_reg, key1_reg, key0_reg};
    assign cfg.nonce = {nonce_hi_reg, nonce_lo_reg};
    assign m_tdata   = {4'b0, valid_bytes, data_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cc20_pkg::REG_KEY0:     key0_reg     <= cfg_data;
                cc20_pkg::REG_KEY1:     key1_reg     <= cfg_data;
                cc20_pkg::REG_KEY2:     key2_reg     <= cfg_data;
                cc20_pkg::REG_KEY3:     key3_reg     <= cfg_data;
                cc20_pkg::REG_NONCE_LO: nonce_lo_reg <= cfg_data;
                cc20_pkg::REG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                cc20_pkg::REG_INIT_CTR: init_ctr_reg <= cfg_data[31:0];
                default:                ;
            endcase
        end
    end

    cc20_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .data_in          (s_tdata[63:0]),
        .byte_count       (s_tdata[67:64]),
        .first_of_message (s_tuser[0]),
        .restart_counter  (s_tuser[1]),
        .init_ctr         (init_ctr_reg),
        .q_full           (full),
        .push             (push),
        .entry            (wr_entry)
    );

    cc20_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .q_valid  (q_valid),
        .pop      (pop),
        .head     (head)
    );

    cc20_back #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .data_out    (data_out),
        .valid_bytes (valid_bytes)
    );

endmodule

`default_nettype wire

/* sim/tb_chacha20_stream_cipher.sv */
// Self-checking testbench for chacha20_stream_cipher: a directed table, then random messages.
// Predicts every result beat with its own ChaCha20 block function; needs only cc20_pkg
// and the RTL.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher;
    import cc20_pkg::*;

    localparam int DR              = 10;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int N_ROWS          = 39;
    localparam int SEND_IDLE [4]   = '{0, 66, 0, 6};
    localparam int RECV_STALL [4]  = '{0, 0, 66, 6};

    localparam logic [31:0] EXPAND_K [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONES32 = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic {ROW_CHUNK, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        first;
        logic        restart;
        logic        typed;
        logic [63:0] exp_data;
    } row_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
    } cipher_beat_t;

    // typed rows: byte count zero gives an all-zero beat
    localparam row_t PLAN [N_ROWS] = '{
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, ONES, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 1'b0, 1'b0, 1'b1, 64'h0},
        '{ROW_CHUNK, REG_KEY0, ONES, 4'd15, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, ONES, 4'd9, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, ONES, 4'd1, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, ONES, 4'd8, 1'b0, 1'b1, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b1, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, ONES, 4'd8, 1'b1, 1'b1, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY0, ONES, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY1, ONES, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY2, ONES, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY3, ONES, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_NONCE_LO, ONES, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_NONCE_HI, ONES32, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_INIT_CTR, ONES32, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b1, 1'b1, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b1, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'hFEDC_BA98_7654_3210, 4'd4, 1'b1, 1'b1, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY0, 64'h0706_0504_0302_0100, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY1, 64'h0F0E_0D0C_0B0A_0908, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY2, 64'h1716_1514_1312_1110, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_KEY3, 64'h1F1E_1D1C_1B1A_1918, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_NONCE_LO, 64'h4A00_0000_0900_0000, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_NONCE_HI, 64'h0, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_REG, REG_INIT_CTR, 64'h1, 4'd0, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b1, 1'b1, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h0, 4'd8, 1'b0, 1'b0, 1'b0, 64'h0},
        '{ROW_CHUNK, REG_KEY0, 64'h5A5A_5A5A_5A5A_5A5A, 4'd0, 1'b0, 1'b0, 1'b1, 64'h0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata = '0;   // data_in[63:0], byte_count[67:64], zero pad
    logic [1:0]           s_tuser = '0;   // first_of_message[0], restart_counter[1]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [71:0]          m_tdata;        // data_out[63:0], valid_bytes[67:64], zero pad
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    // predictor copy of the registers and the keystream state
    logic [63:0]  key_sh [4];
    logic [63:0]  nonce_lo_sh;
    logic [31:0]  nonce_hi_sh;
    logic [31:0]  ctr_init_sh;
    logic [63:0]  ks_chunk [8];
    logic [31:0]  ks_counter;
    logic [2:0]   ks_offset;
    logic         ks_held;
    logic [31:0]  blk_init [16];
    logic [31:0]  blk_w [16];

    cipher_beat_t expected_ct [$];
    cipher_beat_t oldest_ct;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    chacha20_stream_cipher #(.DOUBLE_ROUNDS(DR)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

    task automatic mix(input int a, input int b, input int c, input int d);
        logic [127:0] q;
        q = qround(blk_w[a], blk_w[b], blk_w[c], blk_w[d]);
        {blk_w[a], blk_w[b], blk_w[c], blk_w[d]} = q;
    endtask

    task automatic next_keystream_block();
        for (int i = 0; i < 4; i++)
        begin
            blk_init[i] = EXPAND_K[i];
            blk_init[4 + 2 * i] = key_sh[i][31:0];
            blk_init[5 + 2 * i] = key_sh[i][63:32];
        end
        blk_init[12] = ks_counter;
        blk_init[13] = nonce_lo_sh[31:0];
        blk_init[14] = nonce_lo_sh[63:32];
        blk_init[15] = nonce_hi_sh;
        blk_w = blk_init;
        for (int r = 0; r < DR; r++)
        begin
            mix(0, 4, 8, 12);
            mix(1, 5, 9, 13);
            mix(2, 6, 10, 14);
            mix(3, 7, 11, 15);
            mix(0, 5, 10, 15);
            mix(1, 6, 11, 12);
            mix(2, 7, 8, 13);
            mix(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
        begin
            blk_w[i] = blk_w[i] + blk_init[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            ks_chunk[i] = {blk_w[2 * i + 1], blk_w[2 * i]};
        end
        ks_counter = ks_counter + 32'd1;
    endtask

    task automatic predict_ciphertext(input logic [63:0] d, input logic [3:0] c,
                                      input logic f, input logic r, output cipher_beat_t e);
        logic [63:0] mask;
        if (r)
        begin
            ks_counter = ctr_init_sh;
        end
        if (f || !ks_held)
        begin
            next_keystream_block();
            ks_offset = 3'd0;
            ks_held = 1'b1;
        end
        if (c == 4'd0)
        begin
            mask = 64'h0;
        end
        else if (c >= 4'd8)
        begin
            mask = ONES;
        end
        else
        begin
            mask = (64'h1 << (8 * c)) - 64'h1;
        end
        e.data = (d ^ ks_chunk[ks_offset]) & mask;
        e.count = c;
        ks_offset = ks_offset + 3'd1;
        if (ks_offset == 3'd0)
        begin
            ks_held = 1'b0;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_ct.size() != 0);
    endtask

    task automatic push_chunk(input logic [63:0] d, input logic [3:0] c, input logic f,
                              input logic r, input logic typed, input logic [63:0] typed_data);
        cipher_beat_t e;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'h0, c, d};
        s_tuser <= {r, f};
        do @(posedge clk); while (!s_tready);
        predict_ciphertext(d, c, f, r, e);
        if (typed)
        begin
            e.data = typed_data;
        end
        expected_ct.push_back(e);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_KEY0:     key_sh[0] = val;
            REG_KEY1:     key_sh[1] = val;
            REG_KEY2:     key_sh[2] = val;
            REG_KEY3:     key_sh[3] = val;
            REG_NONCE_LO: nonce_lo_sh = val;
            REG_NONCE_HI: nonce_hi_sh = val[31:0];
            REG_INIT_CTR: ctr_init_sh = val[31:0];
            default:      ;
        endcase
    endtask

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick32();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return ONES32;
            2:       return {32'h0, 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
            default: return {32'h0, $urandom};
        endcase
    endfunction

    task automatic load_random_regs();
        put_reg(REG_KEY0, pick64());
        put_reg(REG_KEY1, pick64());
        put_reg(REG_KEY2, pick64());
        put_reg(REG_KEY3, pick64());
        put_reg(REG_NONCE_LO, pick64());
        put_reg(REG_NONCE_HI, pick32());
        put_reg(REG_INIT_CTR, pick32());
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ct.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat: expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                oldest_ct = expected_ct.pop_front();
                if (m_tdata[63:0] !== oldest_ct.data)
                begin
                    mismatches++;
                    $display("%0t: data_out: expected %h, actual %h",
                             $time, oldest_ct.data, m_tdata[63:0]);
                end
                if (m_tdata[67:64] !== oldest_ct.count)
                begin
                    mismatches++;
                    $display("%0t: valid_bytes: expected %0d, actual %0d",
                             $time, oldest_ct.count, m_tdata[67:64]);
                end
            end
        end
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no beat moved for %0d cycles", $time, quiet_cycles);
            $display("tb_chacha20_stream_cipher: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic        in_reg;
        int          sent;
        int          len;
        logic [3:0]  cnt;
        key_sh = '{64'h0, 64'h0, 64'h0, 64'h0};
        nonce_lo_sh = '0;
        nonce_hi_sh = '0;
        ctr_init_sh = '0;
        ks_chunk = '{default: 64'h0};
        ks_counter = '0;
        ks_offset = '0;
        ks_held = 1'b0;
        in_reg = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_REG)
            begin
                if (!in_reg)
                begin
                    drain();
                    in_reg = 1'b1;
                end
                put_reg(PLAN[i].idx, PLAN[i].data);
            end
            else
            begin
                if (in_reg)
                begin
                    cfg_valid <= 1'b0;
                    in_reg = 1'b0;
                end
                push_chunk(PLAN[i].data, PLAN[i].cnt, PLAN[i].first, PLAN[i].restart,
                           PLAN[i].typed, PLAN[i].exp_data);
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            load_random_regs();
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray beat: any count, any flags
                    push_chunk({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                               1'($urandom), 1'($urandom), 1'b0, 64'h0);
                    sent++;
                end
                else
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        drain();
                    end
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 10);
                    for (int k = 0; k < len; k++)
                    begin
                        cnt = (k == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
                        if (k == 0)
                        begin
                            push_chunk({$urandom, $urandom}, cnt, 1'b1,
                                       $urandom_range(0, 3) != 0, 1'b0, 64'h0);
                        end
                        else
                        begin
                            push_chunk({$urandom, $urandom}, cnt, 1'b0,
                                       $urandom_range(0, 19) == 0, 1'b0, 64'h0);
                        end
                    end
                    sent += len;
                end
            end
        end

        drain();
        repeat (DR + 8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_chacha20_stream_cipher: done, clean");
        end
        else
        begin
            $display("tb_chacha20_stream_cipher: done, errors");
        end
        $finish;
    end

endmodule
